### design/iir4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iir4_pkg
// Shared types and constants for the three-axis fourth-order IIR filter.
// ----------------------------------------------------------------------------
package iir4_pkg;

    localparam int LANES     = 3;
    localparam int COEF_W    = 18;
    localparam int TAPS      = 4;
    localparam int NUM_COEF  = 2 * TAPS + 1;
    localparam int NUM_PAIRS = 4;
    localparam int REG_W     = 2 * COEF_W;
    localparam int IDX_W     = 3;
    localparam int TAP_CW    = 4;

    localparam logic [IDX_W-1:0] REG_B0_B1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_B2_B3 = 3'd1;
    localparam logic [IDX_W-1:0] REG_B4_A1 = 3'd2;
    localparam logic [IDX_W-1:0] REG_A2_A3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_A4    = 3'd4;

    localparam logic [TAP_CW-1:0] TAP_X0   = 4'd0;
    localparam logic [TAP_CW-1:0] TAP_A1   = 4'd5;
    localparam logic [TAP_CW-1:0] TAP_LAST = 4'd8;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic                load;
        logic                mac_en;
        logic [TAP_CW-1:0]   tap;
        logic                finish;
    } lane_ctl_t;

endpackage
`default_nettype wire

### design/iir4_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iir4_in_if
// Sample channel: one signed sample per axis, valid/ready transfer.
// ----------------------------------------------------------------------------
interface iir4_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_x;
    logic signed [SAMPLE_WIDTH-1:0] sample_y;
    logic signed [SAMPLE_WIDTH-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface
`default_nettype wire

### design/iir4_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iir4_out_if
// Result channel: one filtered value per axis, valid/ready transfer.
// ----------------------------------------------------------------------------
interface iir4_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered_x;
    logic signed [SAMPLE_WIDTH-1:0] filtered_y;
    logic signed [SAMPLE_WIDTH-1:0] filtered_z;

    modport source (output valid, output filtered_x, output filtered_y,
                    output filtered_z, input ready);
    modport sink   (input valid, input filtered_x, input filtered_y,
                    input filtered_z, output ready);
endinterface
`default_nettype wire

### design/iir4_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iir4_lane
// One axis: histories, one shared multiplier stepped over the nine taps,
// full-width accumulator, round to nearest and saturate.
// ----------------------------------------------------------------------------
module iir4_lane
    import iir4_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lane_ctl_t                      ctl,
    input  wire coef_t                          coef [NUM_COEF],
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic signed [SAMPLE_WIDTH-1:0]      result
);

    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W  = PROD_W + 4;
    localparam int HIST_IW = $clog2(TAPS);

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [ACC_W-1:0] RND_HALF =
        ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic signed [SAMPLE_WIDTH-1:0] x_cur_reg;
    logic signed [SAMPLE_WIDTH-1:0] xh_reg [TAPS];
    logic signed [SAMPLE_WIDTH-1:0] yh_reg [TAPS];
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [PROD_W-1:0]       prod_next;
    logic                           neg_reg;
    logic                           prod_vld_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;

    logic signed [SAMPLE_WIDTH-1:0] opnd;
    coef_t                          coef_sel;
    logic [TAP_CW-1:0]              tap_m1;
    logic [TAP_CW-1:0]              tap_m5;
    logic signed [ACC_W-1:0]        rnd;
    logic signed [ACC_W-1:0]        shifted;
    logic signed [SAMPLE_WIDTH-1:0] y_next;

    assign tap_m1 = ctl.tap - 4'd1;
    assign tap_m5 = ctl.tap - TAP_A1;

    always_comb
    begin
        priority if (ctl.tap >= TAP_A1)
        begin
            opnd = yh_reg[tap_m5[HIST_IW-1:0]];
        end
        else if (ctl.tap != TAP_X0)
        begin
            opnd = xh_reg[tap_m1[HIST_IW-1:0]];
        end
        else
        begin
            opnd = x_cur_reg;
        end
        coef_sel = (ctl.tap <= TAP_LAST) ? coef[ctl.tap] : '0;
    end

    assign prod_next = PROD_W'(coef_sel) * PROD_W'(opnd);

    assign rnd     = acc_reg + RND_HALF;
    assign shifted = rnd >>> COEF_FRAC_BITS;

    always_comb
    begin
        priority if (shifted > SAT_MAX)
        begin
            y_next = SAT_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            y_next = SAT_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y_next = shifted[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            for (int i = 0; i < TAPS; i++)
            begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end
        else
        begin
            prod_vld_reg <= ctl.mac_en;
            if (ctl.finish)
            begin
                for (int i = TAPS - 1; i > 0; i--)
                begin
                    xh_reg[i] <= xh_reg[i-1];
                    yh_reg[i] <= yh_reg[i-1];
                end
                xh_reg[0] <= x_cur_reg;
                yh_reg[0] <= y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_cur_reg <= sample;
        end
        prod_reg <= prod_next;
        neg_reg  <= (ctl.tap >= TAP_A1);
        if (ctl.load)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= neg_reg ? acc_reg - ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        if (ctl.finish)
        begin
            y_reg <= y_next;
        end
    end

    assign result = y_reg;

endmodule
`default_nettype wire

### design/iir4_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iir4_merge
// Output register: gathers the lane results into one result item and holds
// it until the sink takes the transfer.
// ----------------------------------------------------------------------------
module iir4_merge
    import iir4_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire logic signed [SAMPLE_WIDTH-1:0] lane_y [LANES],
    output logic                                free,
    iir4_out_if.source                          out_ch
);

    logic                           valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] data_reg [LANES];

    assign free = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                data_reg[i] <= lane_y[i];
            end
        end
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.filtered_x = data_reg[0];
    assign out_ch.filtered_y = data_reg[1];
    assign out_ch.filtered_z = data_reg[2];

endmodule
`default_nettype wire

### design/iir4_filter_three_axis_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iir4_filter_three_axis_core
// Three fourth-order direct-form-I IIR filters (x, y, z) on one shared
// coefficient set, rounded to nearest and saturated.
// ----------------------------------------------------------------------------
// One sample item is taken at a time, and a new one only once the last result
// has gone to the output register: each lane steps its single multiplier over
// the nine taps, then drains the product register, then rounds, saturates and
// shifts the histories, and then hands the result to the output register.
// A stalled output holds the lanes in the hand-off step. Coefficient writes
// belong to idle periods; indexes beyond the five registers are dropped.
// ----------------------------------------------------------------------------
module iir4_filter_three_axis_core
    import iir4_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0] cfg_data,
    iir4_in_if.sink               in_ch,
    iir4_out_if.source            out_ch
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [REG_W-1:0]  pair_reg [NUM_PAIRS];
    logic [COEF_W-1:0] a4_reg;
    coef_t             coef [NUM_COEF];

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [TAP_CW-1:0] tap_reg;
    logic [TAP_CW-1:0] tap_next;

    logic              in_fire;
    logic              merge_free;
    logic              merge_load;
    lane_ctl_t         ctl;

    logic signed [SAMPLE_WIDTH-1:0] lane_x [LANES];
    logic signed [SAMPLE_WIDTH-1:0] lane_y [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PAIRS; i++)
            begin
                pair_reg[i] <= '0;
            end
            a4_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_B0_B1: pair_reg[0] <= cfg_data;
                REG_B2_B3: pair_reg[1] <= cfg_data;
                REG_B4_A1: pair_reg[2] <= cfg_data;
                REG_A2_A3: pair_reg[3] <= cfg_data;
                REG_A4:    a4_reg      <= cfg_data[COEF_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            coef[2*i]   = pair_reg[i][COEF_W-1:0];
            coef[2*i+1] = pair_reg[i][REG_W-1:COEF_W];
        end
        coef[NUM_COEF-1] = a4_reg;
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign merge_load  = (state_reg == ST_OUT) && merge_free;

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_RUN;
                    tap_next   = TAP_X0;
                end
            end
            ST_RUN:
            begin
                if (tap_reg == TAP_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 4'd1;
                end
            end
            ST_DRAIN: state_next = ST_FIN;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (merge_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= TAP_X0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    assign ctl.load   = in_fire;
    assign ctl.mac_en = (state_reg == ST_RUN);
    assign ctl.tap    = tap_reg;
    assign ctl.finish = (state_reg == ST_FIN);

    assign lane_x[0] = in_ch.sample_x;
    assign lane_x[1] = in_ch.sample_y;
    assign lane_x[2] = in_ch.sample_z;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        iir4_lane #(
            .SAMPLE_WIDTH   (SAMPLE_WIDTH),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .coef   (coef),
            .sample (lane_x[g]),
            .result (lane_y[g])
        );
    end

    iir4_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (merge_load),
        .lane_y (lane_y),
        .free   (merge_free),
        .out_ch (out_ch)
    );

endmodule
`default_nettype wire

### design/iir4_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iir4_checker
// Port-level checks on the filter core, attached by bind.
// ----------------------------------------------------------------------------
module iir4_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [SAMPLE_WIDTH-1:0] out_x,
    input wire logic [SAMPLE_WIDTH-1:0] out_y,
    input wire logic [SAMPLE_WIDTH-1:0] out_z
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
        else $error("stalled result changed");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while filtering");

    a_new_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a filtering pass");

endmodule

bind iir4_filter_three_axis_core iir4_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iir4_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.filtered_x),
    .out_y     (out_ch.filtered_y),
    .out_z     (out_ch.filtered_z)
);
`default_nettype wire
